FILE: rtl/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// Shared types and constants for the percent escape decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

	localparam int BYTE_W = 8;
	localparam int STAT_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_REJECT_ASCII = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FORBID_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORBID_B = 2'd2;

	localparam logic [BYTE_W-1:0] FORBID_A_RST = 8'h2F;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK = 3'd0;
	localparam logic [STAT_W-1:0] ST_TRUNC = 3'd1;
	localparam logic [STAT_W-1:0] ST_BADHEX = 3'd2;
	localparam logic [STAT_W-1:0] ST_ASCII = 3'd3;
	localparam logic [STAT_W-1:0] ST_FORBID = 3'd4;

	// escape phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT = 2'd1;
	localparam logic [1:0] PH_HI = 2'd2;

	typedef struct packed {
		logic [1:0] phase;
		logic [3:0] high_nibble;
		logic [STAT_W-1:0] reject_code;
	} dec_state_t;

	typedef struct packed {
		logic reject_ascii;
		logic [BYTE_W-1:0] forbid_a;
		logic [BYTE_W-1:0] forbid_b;
	} dec_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic byte_valid;
		logic string_end;
		logic [STAT_W-1:0] status;
	} dec_result_t;

endpackage

FILE: rtl/ped_if.sv
// ----------------------------------------------------------------------------
// ped_if
// Valid/ready channels for escaped input bytes and decoded results.
// ----------------------------------------------------------------------------
interface ped_item_if;
	logic valid;
	logic ready;
	logic [7:0] in_byte;
	logic is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

interface ped_result_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic byte_valid;
	logic string_end;
	logic [2:0] status;

	modport source (output valid, output out_byte, output byte_valid,
		output string_end, output status, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input string_end, input status, output ready);
endinterface

FILE: rtl/ped_step.sv
// ----------------------------------------------------------------------------
// ped_step
// Per-byte decode: next escape state and the optional result for one byte.
// ----------------------------------------------------------------------------
module ped_step
	import ped_pkg::*;
(
	input  dec_state_t        cur,
	input  dec_cfg_t          cfg,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              is_last,
	output dec_state_t        nxt,
	output logic              emit,
	output dec_result_t       res
);

	// {not hex, value}
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = 5'h10;
		if (b >= 8'h30 && b <= 8'h39) v = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h41 && b <= 8'h46) v = {1'b0, 4'(b - 8'h37)};
		else if (b >= 8'h61 && b <= 8'h66) v = {1'b0, 4'(b - 8'h57)};
		return v;
	endfunction

	logic [4:0] hv;
	logic [BYTE_W-1:0] dec_c;
	logic [STAT_W-1:0] code;
	logic reject;

	assign hv = hex_value(in_byte);
	assign dec_c = {cur.high_nibble, hv[3:0]};

	always_comb begin
		nxt = cur;
		emit = 1'b0;
		res = '0;
		code = ST_OK;
		reject = 1'b0;

		if (cur.reject_code != ST_OK) begin
			// swallow until the end of the string
			if (is_last) begin
				emit = 1'b1;
				res.string_end = 1'b1;
				res.status = cur.reject_code;
				nxt = '0;
			end
		end else begin
			case (cur.phase)
				PH_PCT: begin
					if (is_last) begin
						reject = 1'b1;
						code = ST_TRUNC;
					end else if (hv[4]) begin
						reject = 1'b1;
						code = ST_BADHEX;
					end else begin
						nxt.high_nibble = hv[3:0];
						nxt.phase = PH_HI;
					end
				end
				PH_HI: begin
					nxt.phase = PH_IDLE;
					if (hv[4] || dec_c == '0) begin
						reject = 1'b1;
						code = ST_BADHEX;
					end else if (cfg.reject_ascii && !dec_c[7]) begin
						reject = 1'b1;
						code = ST_ASCII;
					end else if ((cfg.forbid_a != '0 && dec_c == cfg.forbid_a) ||
						(cfg.forbid_b != '0 && dec_c == cfg.forbid_b)) begin
						reject = 1'b1;
						code = ST_FORBID;
					end else begin
						emit = 1'b1;
						res.out_byte = dec_c;
						res.byte_valid = 1'b1;
						res.string_end = is_last;
						if (is_last) nxt = '0;
					end
				end
				default: begin
					if (in_byte == 8'h25) begin
						if (is_last) begin
							reject = 1'b1;
							code = ST_TRUNC;
						end else begin
							nxt.phase = PH_PCT;
						end
					end else begin
						nxt.phase = PH_IDLE;
						emit = 1'b1;
						res.out_byte = in_byte;
						res.byte_valid = 1'b1;
						res.string_end = is_last;
						if (is_last) nxt = '0;
					end
				end
			endcase

			if (reject) begin
				if (is_last) begin
					emit = 1'b1;
					res.string_end = 1'b1;
					res.status = code;
					nxt = '0;
				end else begin
					nxt.phase = PH_IDLE;
					nxt.high_nibble = '0;
					nxt.reject_code = code;
				end
			end
		end
	end

endmodule

FILE: rtl/percent_escape_decoder_unit.sv
// ----------------------------------------------------------------------------
// percent_escape_decoder_unit
// Percent-escape URI decoder, one escaped byte per request.
// ----------------------------------------------------------------------------
// Usage:
//   item   : escaped string bytes, is_last marks the final byte of a string.
//   result : decoded bytes; the request with string_end closes the string and
//            carries status (nonzero means drop the whole string). A '%' and
//            its first digit give no result; swallowed bytes give none.
//   cfg    : cfg_we/cfg_index/cfg_data, write only while the unit is idle.
// Timing: a byte is captured into the input stage, decoded against the
//   escape state and lands in the result register. One byte per cycle is
//   sustained while result.ready stays high; the rate is set by the single
//   decode step between the input stage and the result register, which
//   also updates the escape state.
// Stall: while result.ready is low the result register holds, the input
//   stage fills, and item.ready drops once both are occupied.
// Reset: clears valids, escape state, and loads register defaults
//   (ascii check off, forbidden '/' and unused).
// ----------------------------------------------------------------------------
module percent_escape_decoder_unit
	import ped_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	ped_item_if.sink              item,
	ped_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	dec_cfg_t cfg_q;
	dec_state_t state_q;
	dec_state_t state_nxt;

	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic last_s1;

	logic res_valid_q;
	dec_result_t res_q;

	logic emit;
	dec_result_t res_nxt;
	logic adv;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reject_ascii <= 1'b0;
			cfg_q.forbid_a <= FORBID_A_RST;
			cfg_q.forbid_b <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REJECT_ASCII: cfg_q.reject_ascii <= cfg_data[0];
				CFG_FORBID_A: cfg_q.forbid_a <= cfg_data;
				CFG_FORBID_B: cfg_q.forbid_b <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1 request moves on when the result register is free or draining
	assign adv = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			byte_s1 <= item.in_byte;
			last_s1 <= item.is_last;
		end
	end

	ped_step u_step (
		.cur     (state_q),
		.cfg     (cfg_q),
		.in_byte (byte_s1),
		.is_last (last_s1),
		.nxt     (state_nxt),
		.emit    (emit),
		.res     (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				state_q <= state_nxt;
				res_valid_q <= emit;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) res_q <= res_nxt;
	end

	assign result.valid = res_valid_q;
	assign result.out_byte = res_q.out_byte;
	assign result.byte_valid = res_q.byte_valid;
	assign result.string_end = res_q.string_end;
	assign result.status = res_q.status;

endmodule

FILE: rtl/ped_checker.sv
// ----------------------------------------------------------------------------
// ped_checker
// Port-level checks on the decoder result channel.
// ----------------------------------------------------------------------------
module ped_checker
	import ped_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              valid,
	input logic              ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              byte_valid,
	input logic              string_end,
	input logic [STAT_W-1:0] status
);

	// stalled request holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(out_byte) && $stable(status)
			&& $stable(byte_valid) && $stable(string_end))
		else $error("result changed while stalled");

	a_nobyte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !byte_valid |-> out_byte == '0)
		else $error("out_byte nonzero without byte_valid");

	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !string_end |-> status == ST_OK && byte_valid)
		else $error("result inside string without a byte or with status");

	a_reject_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status != ST_OK |-> !byte_valid && string_end &&
			(status == ST_TRUNC || status == ST_BADHEX ||
			 status == ST_ASCII || status == ST_FORBID))
		else $error("bad rejection result");

endmodule

bind percent_escape_decoder_unit ped_checker u_ped_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (result.valid),
	.ready      (result.ready),
	.out_byte   (result.out_byte),
	.byte_valid (result.byte_valid),
	.string_end (result.string_end),
	.status     (result.status)
);
